// ===== design/sld_pkg.sv =====
package sld_pkg;

  localparam int MAX_BYTES_DEF = 15;

  localparam logic [7:0] SYNC_VALUE_RST    = 8'hAC;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd21;
  localparam logic [7:0] TYPE_SIGN_ON      = 8'd2;
  localparam logic [7:0] TYPE_TOOL_DATA    = 8'd3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_REJECT  = 3'd2,
    KIND_OVFL    = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_EMIT_RD = 2'd1,
    S_EMIT_LD = 2'd2
  } state_t;

  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic rd_en;      // read frame store at emit index
    logic load_byte;  // move read byte into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic good_frame; // current item completes a frame with a good checksum
    logic emit_last;  // emit index points at the final frame byte
  } dp_status_t;

endpackage

// ===== design/sld_ctrl.sv =====
module sld_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sld_pkg::dp_status_t st,
  output sld_pkg::ctrl_cmd_t  cmd
);
  import sld_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = st.out_free;
        if (in_tvalid && st.out_free) begin
          cmd.accept = 1'b1;
          if (st.good_frame) begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (st.out_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = st.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sld_dp.sv =====
module sld_dp #(
  parameter int MAX_BYTES = sld_pkg::MAX_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sld_pkg::ctrl_cmd_t           cmd,
  output sld_pkg::dp_status_t          st,
  input  logic                         op,
  input  logic [7:0]                   rx,
  input  logic                         sel,
  input  logic                         cfg_we,
  input  logic [sld_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                   cfg_wdata,
  output logic                         o_valid,
  input  logic                         o_ready,
  output sld_pkg::kind_t               o_kind,
  output logic [3:0]                   o_index,
  output logic [7:0]                   o_value,
  output logic [1:0]                   o_type,
  output logic                         o_last,
  output logic                         o_bad
);
  import sld_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BYTES);
  localparam logic [CNT_W-1:0] CNT_TYPE  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_LEN   = CNT_W'(3);

  logic [7:0]        frame_mem [MAX_BYTES];
  logic [7:0]        rd_data_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        idle_r, idle_nxt;
  logic              bad_r, bad_nxt;
  logic              type_ok_r;
  logic [1:0]        type_r;
  logic [7:0]        len_r;
  logic [7:0]        sync_r;
  logic [7:0]        tout_r;
  logic [ADDR_W-1:0] emit_idx_r;
  logic [CNT_W-1:0]  emit_len_r;

  logic              out_valid_r;
  kind_t             kind_r;
  logic [3:0]        index_r;
  logic [7:0]        value_r;
  logic [1:0]        type_out_r;
  logic              last_r;
  logic              bad_out_r;

  logic [CNT_W-1:0]  cnt_inc;
  logic [7:0]        idle_inc;
  logic [7:0]        len_now;
  logic              take_byte, ovfl, complete, chk_ok, good, tick, tmo;
  kind_t             kind_now;
  logic [1:0]        type_now;

  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign idle_inc  = idle_r + 8'd1;
  assign take_byte = sel && (op == OP_BYTE) && ((cnt_r != '0) || (rx == sync_r));
  assign ovfl      = take_byte && (cnt_inc == CNT_MAX);
  // length byte is the one arriving now when the third byte lands
  assign len_now   = (cnt_inc == CNT_LEN) ? rx : len_r;
  assign chk_ok    = (rx == sum_r);
  assign complete  = take_byte && !ovfl && (cnt_inc >= CNT_LEN) &&
                     (8'(cnt_inc) == len_now) && type_ok_r;
  assign good      = complete && chk_ok;
  assign tick      = sel && (op == OP_TICK) && (cnt_r == '0);
  assign tmo       = tick && (idle_inc == tout_r);

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    idle_nxt = idle_r;
    bad_nxt  = bad_r;
    kind_now = KIND_NONE;
    type_now = 2'd0;
    if (!sel) begin
      cnt_nxt  = '0;
      sum_nxt  = '0;
      idle_nxt = '0;
      bad_nxt  = 1'b0;
    end else if (take_byte) begin
      if (ovfl) begin
        cnt_nxt  = '0;
        sum_nxt  = '0;
        kind_now = KIND_OVFL;
      end else if (complete) begin
        cnt_nxt  = '0;
        sum_nxt  = '0;
        idle_nxt = '0;
        bad_nxt  = !chk_ok;
        kind_now = chk_ok ? KIND_GOOD : KIND_REJECT;
        type_now = type_r;
      end else begin
        cnt_nxt = cnt_inc;
        sum_nxt = sum_r + rx;
      end
    end else if (tick) begin
      idle_nxt = tmo ? 8'd0 : idle_inc;
      if (tmo) begin
        bad_nxt  = 1'b1;
        kind_now = KIND_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      idle_r <= '0;
      bad_r  <= 1'b0;
      sync_r <= SYNC_VALUE_RST;
      tout_r <= TIMEOUT_TICKS_RST;
    end else begin
      if (cmd.accept) begin
        cnt_r  <= cnt_nxt;
        sum_r  <= sum_nxt;
        idle_r <= idle_nxt;
        bad_r  <= bad_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SYNC_VALUE:    sync_r <= cfg_wdata;
          REG_TIMEOUT_TICKS: tout_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // frame store and header bytes; every taken byte is stored, header included
  always_ff @(posedge clk) begin
    if (cmd.accept && take_byte) begin
      frame_mem[cnt_r[ADDR_W-1:0]] <= rx;
      if (cnt_inc == CNT_TYPE) begin
        type_ok_r <= (rx == TYPE_SIGN_ON) || (rx == TYPE_TOOL_DATA);
        type_r    <= rx[1:0];
      end
      if (cnt_inc == CNT_LEN) begin
        len_r <= rx;
      end
    end
    if (cmd.rd_en) begin
      rd_data_r <= frame_mem[emit_idx_r];
    end
    if (cmd.accept) begin
      emit_idx_r <= '0;
      emit_len_r <= cnt_inc;
    end else if (cmd.load_byte) begin
      emit_idx_r <= emit_idx_r + ADDR_W'(1);
    end
  end

  assign st.out_free   = !out_valid_r || o_ready;
  assign st.good_frame = good;
  assign st.emit_last  = ((CNT_W'(emit_idx_r) + CNT_W'(1)) == emit_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.accept && !good) || cmd.load_byte) begin
      out_valid_r <= 1'b1;
    end else if (o_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !good) begin
      kind_r     <= kind_now;
      index_r    <= 4'd0;
      value_r    <= 8'd0;
      type_out_r <= type_now;
      last_r     <= 1'b1;
      bad_out_r  <= bad_nxt;
    end else if (cmd.load_byte) begin
      kind_r     <= KIND_GOOD;
      index_r    <= 4'(emit_idx_r);
      value_r    <= rd_data_r;
      type_out_r <= type_r;
      last_r     <= st.emit_last;
      bad_out_r  <= bad_r;
    end
  end

  assign o_valid = out_valid_r;
  assign o_kind  = kind_r;
  assign o_index = index_r;
  assign o_value = value_r;
  assign o_type  = type_out_r;
  assign o_last  = last_r;
  assign o_bad   = bad_out_r;

endmodule

// ===== design/sync_length_checksum_deframer_top.sv =====
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tdata: rx_byte, high_side_selected; tuser: opcode
// out_     out  out_tvalid/out_tready  tdata: byte_index..status_bad; tuser: kind; tlast
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// An item that yields one result is taken when the output register is free; the next can follow at once
// only if the held result leaves the output register in that same cycle.
// A good frame holds off input after its item until all its bytes are emitted: each byte
// is one registered frame-store read (S_EMIT_RD) followed by one output load (S_EMIT_LD).
// Output stalls stretch emission; input is taken only when the output slot is free.
// rst_n is synchronous; the frame store is not cleared and needs no sweep.
module sync_length_checksum_deframer_top #(
  parameter int MAX_BYTES = sld_pkg::MAX_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // rx_byte[7:0], high_side_selected[8]
  input  logic                          in_tuser,   // opcode[0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // byte_index[3:0], byte_value[11:4], frame_type[13:12], status_bad[14]
  output logic [15:0]                   out_tdata,
  output logic [2:0]                    out_tuser,  // kind[2:0]
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import sld_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  kind_t      o_kind;
  logic [3:0] o_index;
  logic [7:0] o_value;
  logic [1:0] o_type;
  logic       o_bad;

  assign cfg_ready = 1'b1;

  sld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sld_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .op        (in_tuser),
    .rx        (in_tdata[7:0]),
    .sel       (in_tdata[8]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .o_valid   (out_tvalid),
    .o_ready   (out_tready),
    .o_kind    (o_kind),
    .o_index   (o_index),
    .o_value   (o_value),
    .o_type    (o_type),
    .o_last    (out_tlast),
    .o_bad     (o_bad)
  );

  assign out_tuser = o_kind;
  assign out_tdata = {1'b0, o_bad, o_type, o_value, o_index};

`ifndef ASSERT_OFF
  // a good frame blocks input on the following cycle while bytes stream out
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && st.good_frame) |=> !in_tready)
    else $error("input accepted during frame emission");

  // every result other than a frame byte is the only result of its item
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_GOOD)) |-> out_tlast)
    else $error("non-byte result without last");

  // frame bytes always report a clear bad-data status
  a_good_clears_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_GOOD)) |-> !out_tdata[14])
    else $error("good frame byte with bad status");

  // index and value fields are zero except on frame bytes
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_GOOD)) |-> (out_tdata[11:0] == 12'd0))
    else $error("nonzero index or value on non-byte result");
`endif

endmodule
